### rtl/ktdf_pkg.sv
// ----------------------------------------------------------------------------
// ktdf_pkg
// Shared types and kanji code point constants of the time and date formatter.
// ----------------------------------------------------------------------------
package ktdf_pkg;

  localparam int unsigned MaxCodes = 8;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned NumW     = 7;
  localparam int unsigned IdxW     = $clog2(MaxCodes);
  localparam int unsigned CntW     = IdxW + 1;

  typedef logic [CodeW-1:0] code_t;

  typedef enum logic [1:0] {
    REQ_TIME    = 2'd0,
    REQ_DATE    = 2'd1,
    REQ_WEEKDAY = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_e;

  localparam code_t CpHour   = 16'd26178;
  localparam code_t CpMinute = 16'd20998;
  localparam code_t CpWeek   = 16'd26332;
  localparam code_t CpDay    = 16'd26085;
  localparam code_t CpMonth  = 16'd26376;
  localparam code_t CpTen    = 16'd21313;

  localparam logic [NumW-1:0] NumMax = 7'd99;
  localparam logic [NumW-1:0] WdMax  = 7'd6;

  typedef struct packed {
    code_t [MaxCodes-1:0] codes;
    logic  [CntW-1:0]     cnt;
  } job_t;

  function automatic code_t digit_cp(input logic [3:0] d);
    code_t r;
    unique case (d)
      4'd1:    r = 16'd19968;
      4'd2:    r = 16'd20108;
      4'd3:    r = 16'd19977;
      4'd4:    r = 16'd22235;
      4'd5:    r = 16'd20116;
      4'd6:    r = 16'd20845;
      4'd7:    r = 16'd19971;
      4'd8:    r = 16'd20843;
      4'd9:    r = 16'd20061;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic code_t weekday_cp(input logic [2:0] d);
    code_t r;
    unique case (d)
      3'd0:    r = 16'd26085;
      3'd1:    r = 16'd26376;
      3'd2:    r = 16'd28779;
      3'd3:    r = 16'd27700;
      3'd4:    r = 16'd26408;
      3'd5:    r = 16'd37329;
      3'd6:    r = 16'd22303;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/kanji_time_date_formatter.sv
// ----------------------------------------------------------------------------
// kanji_time_date_formatter
// Path: with the serializer idle, a request passes the input register, then
// the result register, before its first code point is offered on the output.
// Throughput: one code point per cycle while out_ready_i is high; a request
// is sent as 1 to 8 code points by the output serializer.
// Reset: rst_ni asynchronous active low, clears input and serializer valids.
// ----------------------------------------------------------------------------
module kanji_time_date_formatter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [ktdf_pkg::NumW-1:0]  first_number_i,
  input  logic [ktdf_pkg::NumW-1:0]  second_number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ktdf_pkg::CodeW-1:0] code_point_o,
  output logic                       last_o
);
  import ktdf_pkg::*;

  logic                s1_vld_q;
  logic [1:0]          s1_type_q;
  logic [NumW-1:0]     s1_first_q;
  logic [NumW-1:0]     s1_second_q;

  job_t                job;
  code_t [MaxCodes-1:0] codes_q;
  logic [CntW-1:0]     cnt_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                busy_q;

  logic                is_last, job_done, job_load, in_take;

  ktdf_encoder u_enc (
    .req_type_i      (s1_type_q),
    .first_number_i  (s1_first_q),
    .second_number_i (s1_second_q),
    .job_o           (job)
  );

  assign is_last  = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign job_done = busy_q & out_ready_i & is_last;
  assign job_load = s1_vld_q & (~busy_q | job_done);
  assign in_take  = in_valid_i & in_ready_o;
  assign in_ready_o = ~s1_vld_q | job_load;

  always_comb begin
    idx_d = idx_q;
    if (job_load) begin
      idx_d = '0;
    end else if (busy_q && out_ready_i) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      busy_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (in_take) begin
        s1_vld_q <= 1'b1;
      end else if (job_load) begin
        s1_vld_q <= 1'b0;
      end
      if (job_load) begin
        busy_q <= 1'b1;
      end else if (job_done) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_type_q   <= req_type_i;
      s1_first_q  <= first_number_i;
      s1_second_q <= second_number_i;
    end
    if (job_load) begin
      codes_q <= job.codes;
      cnt_q   <= job.cnt;
    end
  end

  assign out_valid_o  = busy_q;
  assign code_point_o = codes_q[idx_q];
  assign last_o       = is_last;

endmodule

### rtl/ktdf_encoder.sv
// ----------------------------------------------------------------------------
// ktdf_encoder
// Turns one registered request into its list of kanji code points and count.
// ----------------------------------------------------------------------------
module ktdf_encoder (
  input  logic [1:0]                 req_type_i,
  input  logic [ktdf_pkg::NumW-1:0]  first_number_i,
  input  logic [ktdf_pkg::NumW-1:0]  second_number_i,
  output ktdf_pkg::job_t             job_o
);
  import ktdf_pkg::*;

  typedef struct packed {
    code_t [3:0] codes;
    logic  [2:0] cnt;
  } numeral_t;

  function automatic numeral_t numeral(input logic [NumW-1:0] raw, input code_t suffix);
    numeral_t         r;
    logic [NumW-1:0]  n;
    logic [14:0]      prod;
    logic [3:0]       tens;
    logic [7:0]       tens10;
    logic [3:0]       units;
    logic [2:0]       c;
    r     = '0;
    n     = (raw > NumMax) ? NumMax : raw;
    prod  = 15'(n) * 15'd205;
    tens  = prod[14:11];
    tens10 = 8'(tens) * 8'd10;
    units = 4'(8'(n) - tens10);
    c     = '0;
    if (n != '0) begin
      if (n <= 7'd9) begin
        r.codes[c[1:0]] = digit_cp(n[3:0]);
        c = c + 3'd1;
      end else if (n == 7'd10) begin
        r.codes[c[1:0]] = CpTen;
        c = c + 3'd1;
      end else begin
        if (tens > 4'd1) begin
          r.codes[c[1:0]] = digit_cp(tens);
          c = c + 3'd1;
        end
        r.codes[c[1:0]] = CpTen;
        c = c + 3'd1;
        if (units != 4'd0) begin
          r.codes[c[1:0]] = digit_cp(units);
          c = c + 3'd1;
        end
      end
      r.codes[c[1:0]] = suffix;
      c = c + 3'd1;
    end
    r.cnt = c;
    return r;
  endfunction

  numeral_t num_a, num_b;
  job_t     job;
  logic     is_time;
  logic [IdxW-1:0] off;

  assign is_time = (req_type_i == REQ_TIME);

  always_comb begin
    num_a = numeral(first_number_i, is_time ? CpHour : CpDay);
    num_b = numeral(second_number_i, is_time ? CpMinute : CpMonth);
  end

  always_comb begin
    job = '0;
    off = '0;
    unique case (req_type_e'(req_type_i))
      REQ_TIME, REQ_DATE: begin
        for (int p = 0; p < MaxCodes; p++) begin
          off = IdxW'(p) - IdxW'(num_a.cnt);
          if (CntW'(p) < CntW'(num_a.cnt)) begin
            job.codes[p] = num_a.codes[p[1:0]];
          end else if (off < IdxW'(num_b.cnt)) begin
            job.codes[p] = num_b.codes[off[1:0]];
          end
        end
        job.cnt = CntW'(num_a.cnt) + CntW'(num_b.cnt);
      end
      REQ_WEEKDAY: begin
        if (first_number_i <= WdMax) begin
          job.codes[0] = weekday_cp(first_number_i[2:0]);
          job.codes[1] = CpWeek;
          job.codes[2] = CpDay;
          job.cnt      = CntW'(3);
        end
      end
      default: job = '0;
    endcase
    if (job.cnt == '0) begin
      job.codes[0] = '0;
      job.cnt      = CntW'(1);
    end
  end

  assign job_o = job;

endmodule
